### rtl/clt_pkg.sv
// Shared types and constants of the cluster label table compactor.
// No dependencies; imported by every module of the block.
package clt_pkg;

  localparam int MaxPoints = 64;
  localparam int PtW       = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);
  localparam int LabW      = PtW + 1;
  localparam int ClW       = 8;
  localparam int InW       = 16;
  localparam int OutW      = 32;

  localparam logic [LabW-1:0] LabNone = '1;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_MOVE  = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_POINT   = 2'd1,
    STS_CLUSTER = 2'd2
  } status_e;

  typedef struct packed {
    logic [PtW-1:0]  moved_from;
    logic            relabeled;
    logic [CntW-1:0] cluster_size;
    logic [CntW-1:0] num_clusters;
    logic [LabW-1:0] label;
    status_e         status;
  } res_t;

  typedef struct packed {
    logic latch;
    logic clear;
    logic lab_rd_p;
    logic chk;
    logic sz_rd_old;
    logic sz_dec_old;
    logic lab_wr_p;
    logic sz_rd_c;
    logic sz_inc_c;
    logic cmp_chk;
    logic sz_rd_last;
    logic sz_cp_last;
    logic sz_zero_last;
    logic walk_start;
    logic walk;
    logic fin_lab_take;
    logic fin_sz_rd;
    logic fin_sz_take;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  pvalid;
    logic  range_err;
    logic  same;
    logic  rd_alloc;
    logic  c_alloc;
    logic  cmp_need;
    logic  cmp_short;
    logic  rel;
    logic  walk_done;
    logic  out_free;
  } sts_t;

endpackage

### rtl/clt_dpath.sv
// Datapath: label and size memories, cluster count, walk counter, result register.
// Depends on clt_pkg; driven by clt_ctrl through cmd_t, reports through sts_t.
module clt_dpath import clt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [InW-1:0]    in_data_i,
  input  logic              cfg_we_i,
  input  logic [CntW-1:0]   cfg_wdata_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [OutW-1:0]   out_data_o
);

  func_e                 func_q;
  logic [PtW-1:0]        pt_q;
  logic signed [ClW-1:0] cl_q;
  logic                  pvalid_q;
  logic [CntW-1:0]       piu_q, cnt_q, npts;
  logic [LabW-1:0]       old_q, fin_lab_q;
  logic [CntW-1:0]       oldsz_q, fin_sz_q;
  logic [PtW-1:0]        last_q, from_q;
  logic                  rel_q;
  status_e               stat_q;

  logic [LabW-1:0]       lab_mem [MaxPoints];
  logic [MaxPoints-1:0]  lab_vld_q;
  logic [LabW-1:0]       lab_rdat_q;
  logic                  lab_rvld_q;
  logic [CntW-1:0]       sz_mem [MaxPoints];
  logic [MaxPoints-1:0]  sz_vld_q;
  logic [CntW-1:0]       sz_rdat_q;
  logic                  sz_rvld_q;

  logic [CntW-1:0]       widx_q;
  logic                  pend_q;
  logic [PtW-1:0]        pidx_q;
  logic                  walk_more;

  res_t                  out_q;
  logic                  out_vld_q;

  logic [LabW-1:0]       lab_rd;
  logic [CntW-1:0]       sz_rd, sz_dec;
  logic                  lab_re, lab_we, sz_re, sz_we;
  logic [PtW-1:0]        lab_raddr, lab_waddr, sz_raddr, sz_waddr;
  logic [LabW-1:0]       lab_wdat;
  logic [CntW-1:0]       sz_wdat;
  logic                  range_err, walk_hit;
  logic [CntW-1:0]       c_plus1;

  assign npts      = (piu_q > CntW'(MaxPoints)) ? CntW'(MaxPoints) : piu_q;
  assign lab_rd    = lab_rvld_q ? lab_rdat_q : LabNone;
  assign sz_rd     = sz_rvld_q ? sz_rdat_q : '0;
  assign sz_dec    = (sz_rd != '0) ? sz_rd - CntW'(1) : sz_rd;
  assign walk_more = widx_q < CntW'(MaxPoints);
  assign walk_hit  = pend_q && (lab_rd == {1'b0, last_q});
  assign c_plus1   = CntW'(cl_q[PtW-1:0]) + CntW'(1);

  always_comb begin
    range_err = 1'b0;
    case (func_q)
      FUNC_LOAD: begin
        range_err = (cl_q < -8'sd1) || (cl_q >= $signed(ClW'(MaxPoints)));
      end
      FUNC_MOVE: begin
        range_err = (cl_q < -8'sd1) || (cl_q > $signed(ClW'(cnt_q))) ||
                    (cl_q >= $signed(ClW'(MaxPoints)));
      end
      default: range_err = 1'b0;
    endcase
  end

  // label memory port selection
  always_comb begin
    lab_re    = cmd_i.lab_rd_p || (cmd_i.walk && walk_more);
    lab_raddr = cmd_i.walk ? widx_q[PtW-1:0] : pt_q;
    lab_we    = cmd_i.lab_wr_p || walk_hit;
    lab_waddr = cmd_i.lab_wr_p ? pt_q : pidx_q;
    lab_wdat  = cmd_i.lab_wr_p ? cl_q[LabW-1:0] : old_q;
  end

  // size memory port selection
  always_comb begin
    sz_re    = cmd_i.sz_rd_old || cmd_i.sz_rd_c || cmd_i.sz_rd_last || cmd_i.fin_sz_rd;
    sz_raddr = old_q[PtW-1:0];
    if (cmd_i.sz_rd_c) begin
      sz_raddr = cl_q[PtW-1:0];
    end else if (cmd_i.sz_rd_last) begin
      sz_raddr = last_q;
    end else if (cmd_i.fin_sz_rd) begin
      sz_raddr = fin_lab_q[PtW-1:0];
    end
    sz_we    = cmd_i.sz_dec_old || cmd_i.sz_inc_c || cmd_i.sz_cp_last || cmd_i.sz_zero_last;
    sz_waddr = old_q[PtW-1:0];
    sz_wdat  = sz_dec;
    if (cmd_i.sz_inc_c) begin
      sz_waddr = cl_q[PtW-1:0];
      sz_wdat  = sz_rd + CntW'(1);
    end else if (cmd_i.sz_cp_last) begin
      sz_wdat  = sz_rd;
    end else if (cmd_i.sz_zero_last) begin
      sz_waddr = last_q;
      sz_wdat  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lab_we) begin
      lab_mem[lab_waddr] <= lab_wdat;
    end
    if (lab_re) begin
      lab_rdat_q <= lab_mem[lab_raddr];
    end
    if (sz_we) begin
      sz_mem[sz_waddr] <= sz_wdat;
    end
    if (sz_re) begin
      sz_rdat_q <= sz_mem[sz_raddr];
    end
  end

  // valid bits, count, config and handshake state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lab_vld_q  <= '0;
      sz_vld_q   <= '0;
      lab_rvld_q <= 1'b0;
      sz_rvld_q  <= 1'b0;
      cnt_q      <= '0;
      piu_q      <= CntW'(MaxPoints);
      pend_q     <= 1'b0;
      widx_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        piu_q <= cfg_wdata_i;
      end
      if (cmd_i.clear) begin
        lab_vld_q <= '0;
        sz_vld_q  <= '0;
      end else begin
        if (lab_we) begin
          lab_vld_q[lab_waddr] <= 1'b1;
        end
        if (sz_we) begin
          sz_vld_q[sz_waddr] <= 1'b1;
        end
      end
      if (lab_re) begin
        lab_rvld_q <= lab_vld_q[lab_raddr];
      end
      if (sz_re) begin
        sz_rvld_q <= sz_vld_q[sz_raddr];
      end

      if (cmd_i.clear) begin
        cnt_q <= '0;
      end else if (cmd_i.sz_inc_c) begin
        if (func_q == FUNC_LOAD && c_plus1 > cnt_q) begin
          cnt_q <= c_plus1;
        end else if (func_q == FUNC_MOVE && CntW'(cl_q[PtW-1:0]) == cnt_q) begin
          cnt_q <= cnt_q + CntW'(1);
        end
      end else if (cmd_i.cmp_chk && sts_o.cmp_need && sts_o.cmp_short) begin
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - CntW'(1);
        end
      end else if (cmd_i.sz_zero_last) begin
        cnt_q <= cnt_q - CntW'(1);
      end

      if (cmd_i.walk_start) begin
        widx_q <= '0;
        pend_q <= 1'b0;
      end else if (cmd_i.walk) begin
        pend_q <= walk_more;
        if (walk_more) begin
          widx_q <= widx_q + CntW'(1);
        end
      end

      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // item payload and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q    <= func_e'(in_data_i[1:0]);
      pt_q      <= in_data_i[PtW+1:2];
      cl_q      <= $signed(in_data_i[PtW+2+ClW-1:PtW+2]);
      pvalid_q  <= CntW'(in_data_i[PtW+1:2]) < npts;
      stat_q    <= (func_e'(in_data_i[1:0]) != FUNC_CLEAR &&
                    !(CntW'(in_data_i[PtW+1:2]) < npts)) ? STS_POINT : STS_OK;
      rel_q     <= 1'b0;
      from_q    <= '0;
      fin_lab_q <= LabNone;
      fin_sz_q  <= '0;
    end
    if (cmd_i.chk) begin
      old_q <= lab_rd;
      if (range_err) begin
        stat_q <= STS_CLUSTER;
      end
    end
    if (cmd_i.sz_dec_old) begin
      oldsz_q <= sz_dec;
    end
    if (cmd_i.cmp_chk) begin
      last_q <= PtW'(cnt_q - CntW'(1));
    end
    if (cmd_i.sz_cp_last && sz_rd != '0) begin
      rel_q  <= 1'b1;
      from_q <= last_q;
    end
    if (cmd_i.walk) begin
      pidx_q <= widx_q[PtW-1:0];
    end
    if (cmd_i.fin_lab_take) begin
      fin_lab_q <= lab_rd;
      fin_sz_q  <= '0;
    end
    if (cmd_i.fin_sz_take) begin
      fin_sz_q <= sz_rd;
    end
    if (cmd_i.out_load) begin
      out_q.status       <= stat_q;
      out_q.label        <= fin_lab_q;
      out_q.num_clusters <= cnt_q;
      out_q.cluster_size <= fin_sz_q;
      out_q.relabeled    <= rel_q;
      out_q.moved_from   <= from_q;
    end
  end

  always_comb begin
    sts_o.func      = func_q;
    sts_o.pvalid    = pvalid_q;
    sts_o.range_err = range_err;
    sts_o.same      = $signed(ClW'($signed(lab_rd))) == cl_q;
    sts_o.rd_alloc  = !lab_rd[LabW-1];
    sts_o.c_alloc   = !cl_q[ClW-1];
    sts_o.cmp_need  = !old_q[LabW-1] && (oldsz_q == '0);
    sts_o.cmp_short = (cnt_q <= CntW'(1)) ||
                      (CntW'(old_q[PtW-1:0]) + CntW'(1) == cnt_q);
    sts_o.rel       = rel_q;
    sts_o.walk_done = !walk_more && !pend_q;
    sts_o.out_free  = !out_vld_q || out_ready_i;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = OutW'(out_q);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxPoints))
    else $error("cluster count above point capacity");

  a_walk_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ({1'b0, last_q} == cnt_q))
    else $error("renumber walk with count not dropped to last cluster");

  a_rel_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.relabeled) |-> (out_q.status == STS_OK))
    else $error("renumbering reported on a rejected item");

endmodule

### rtl/clt_ctrl.sv
// Controller: sequences one item at a time through the datapath.
// Depends on clt_pkg; drives clt_dpath through cmd_t and reads sts_t.
module clt_ctrl import clt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_LRD, S_LCHK, S_DRD, S_DWR, S_WLAB, S_IRD, S_IWR,
    S_CCHK, S_LSRD, S_LSCP, S_LSZ0, S_WALK, S_FLR, S_FLD, S_FSR, S_FSD, S_DONE
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.func == FUNC_CLEAR) begin
          cmd_o.clear = 1'b1;
          state_d     = S_DONE;
        end else if (!sts_i.pvalid) begin
          state_d = S_DONE;
        end else begin
          state_d = S_LRD;
        end
      end
      S_LRD: begin
        cmd_o.lab_rd_p = 1'b1;
        state_d        = S_LCHK;
      end
      S_LCHK: begin
        cmd_o.chk = 1'b1;
        if (sts_i.func == FUNC_READ || sts_i.range_err || sts_i.same) begin
          state_d = S_FLR;
        end else if (sts_i.rd_alloc) begin
          state_d = S_DRD;
        end else begin
          state_d = S_WLAB;
        end
      end
      S_DRD: begin
        cmd_o.sz_rd_old = 1'b1;
        state_d         = S_DWR;
      end
      S_DWR: begin
        cmd_o.sz_dec_old = 1'b1;
        state_d          = S_WLAB;
      end
      S_WLAB: begin
        cmd_o.lab_wr_p = 1'b1;
        if (sts_i.c_alloc) begin
          state_d = S_IRD;
        end else if (sts_i.func == FUNC_MOVE) begin
          state_d = S_CCHK;
        end else begin
          state_d = S_FLR;
        end
      end
      S_IRD: begin
        cmd_o.sz_rd_c = 1'b1;
        state_d       = S_IWR;
      end
      S_IWR: begin
        cmd_o.sz_inc_c = 1'b1;
        state_d        = (sts_i.func == FUNC_MOVE) ? S_CCHK : S_FLR;
      end
      S_CCHK: begin
        cmd_o.cmp_chk = 1'b1;
        state_d       = (sts_i.cmp_need && !sts_i.cmp_short) ? S_LSRD : S_FLR;
      end
      S_LSRD: begin
        cmd_o.sz_rd_last = 1'b1;
        state_d          = S_LSCP;
      end
      S_LSCP: begin
        cmd_o.sz_cp_last = 1'b1;
        state_d          = S_LSZ0;
      end
      S_LSZ0: begin
        cmd_o.sz_zero_last = 1'b1;
        cmd_o.walk_start   = 1'b1;
        state_d            = sts_i.rel ? S_WALK : S_FLR;
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_done) begin
          state_d = S_FLR;
        end
      end
      S_FLR: begin
        cmd_o.lab_rd_p = 1'b1;
        state_d        = S_FLD;
      end
      S_FLD: begin
        cmd_o.fin_lab_take = 1'b1;
        state_d            = sts_i.rd_alloc ? S_FSR : S_DONE;
      end
      S_FSR: begin
        cmd_o.fin_sz_rd = 1'b1;
        state_d         = S_FSD;
      end
      S_FSD: begin
        cmd_o.fin_sz_take = 1'b1;
        state_d           = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DEC))
    else $error("accepted item not decoded");

  a_walk_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> sts_i.rel)
    else $error("relabel walk without a renumbered cluster");

endmodule

### rtl/cluster_label_table_compactor.sv
// Top level of the cluster label table compactor.
// Depends on clt_pkg, clt_ctrl and clt_dpath.
//
// One item is handled at a time. Clear items and items with an out-of-range point skip
// the memory accesses and go straight to the result; a move that empties a cluster
// other than the last one and renumbers the last cluster adds a walk over the label
// memory at one entry per cycle. A waiting result sits in the output register while
// the next item is accepted. Memory contents are marked by per-entry valid bits, so
// reset and clear act at once with no clearing pass.
module cluster_label_table_compactor import clt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,     // points_in_use
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [InW-1:0]  s_axis_tdata,    // func[1:0], point[7:2], cluster[15:8]
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata     // status[1:0], label[8:2], num_clusters[15:9],
                                           // cluster_size[22:16], relabeled[23],
                                           // moved_from[29:24]
);

  cmd_t cmd;
  sts_t sts;

  clt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  clt_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule
